// ===== hw/rtl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int LVL_W = 5;

    function automatic logic [LVL_W-1:0] bit_len(input logic [31:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int b = 0; b < 32; b++) begin
            if (v[b]) begin
                r = LVL_W'(b + 1);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// Buddy page allocator. Pulse start while busy is low; one result word follows
// on o_done for a single cycle, and must be taken then since it cannot be held
// off. A request reads each free-map node it visits through the single-port
// free-map RAM: an allocation scans levels from the requested size upward
// (worst case about 2*region nodes), then splits level by level; a free checks
// ancestors and the block's subtree and then merges level by level. After
// reset and after every region_pages write the free map is cleared, one entry
// per cycle over all 2*TOP entries (TOP being the largest power of two not
// above MAX_PAGES), then the root of a non-empty region is seeded free, all
// with busy high.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [10:0] i_page_count,
    input  logic [9:0]  i_block_offset,
    output logic        o_done,
    output logic        o_status,
    output logic [9:0]  o_granted_offset,
    output logic [10:0] o_free_total
);

    localparam int TOP_LOG = $clog2(MAX_PAGES + 1) - 1;
    localparam int TOP     = 1 << TOP_LOG;
    localparam int AW      = TOP_LOG + 1;
    localparam int IW      = TOP_LOG + 1;
    localparam int CW      = (TOP_LOG + 2 > 12) ? TOP_LOG + 2 : 12;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SEED, S_START,
        S_ARD, S_ACHK, S_ASPW,
        S_FARD, S_FACHK, S_FDRD, S_FDCHK,
        S_MINIT, S_MRD, S_MCHK, S_MSET
    } t_state;

    t_state           r_state;
    logic [10:0]      r_region;
    logic [AW-1:0]    r_clr;
    logic [LVL_W-1:0] r_k;
    logic [IW-1:0]    r_i;
    logic             r_sib;
    logic [CW-1:0]    r_cnt;
    logic             r_mode;
    logic [LVL_W-1:0] r_ku;
    logic [9:0]       r_off;
    logic [CW-1:0]    r_free;
    logic             r_done;
    logic             r_status;
    logic [9:0]       r_granted;

    logic [CW-1:0]    w_want;
    logic             w_empty;
    logic [LVL_W-1:0] w_reg_log;
    logic [CW-1:0]    w_reg_size;
    logic [CW-1:0]    w_u;
    logic [CW-1:0]    w_off;
    logic             w_free_ok;
    logic [AW-1:0]    w_node;
    logic [AW-1:0]    w_addr;
    logic             w_we;
    logic             w_wdata;
    logic             w_rdata;
    logic [10:0]      w_nm1;

    assign w_want     = (CW'(r_region) > CW'(TOP)) ? CW'(TOP) : CW'(r_region);
    assign w_empty    = (w_want == '0);
    assign w_reg_log  = w_empty ? '0 : bit_len(32'(w_want)) - LVL_W'(1);
    assign w_reg_size = w_empty ? '0 : (CW'(1) << w_reg_log);
    assign w_u        = CW'(1) << r_ku;
    assign w_off      = CW'(r_off);
    assign w_free_ok  = !w_empty && (r_ku <= w_reg_log) && ((w_off & (w_u - CW'(1))) == '0)
                        && ((w_off + w_u) <= w_reg_size);
    assign w_node     = (AW'(TOP) >> r_k) + AW'(r_i ^ IW'(r_sib));
    assign w_addr     = (r_state == S_CLR) ? r_clr : w_node;
    assign w_nm1      = (i_page_count == '0) ? '0 : i_page_count - 11'd1;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = 1'b0;
        case (r_state)
            S_CLR:  w_we = 1'b1;
            S_SEED: begin
                w_we    = 1'b1;
                w_wdata = 1'b1;
            end
            S_ACHK: w_we = w_rdata;
            S_ASPW: begin
                w_we    = 1'b1;
                w_wdata = 1'b1;
            end
            S_MCHK: w_we = w_rdata;
            S_MSET: begin
                w_we    = 1'b1;
                w_wdata = 1'b1;
            end
            default: w_we = 1'b0;
        endcase
    end

    bpa_ram #(
        .WIDTH(1),
        .DEPTH(2 * TOP)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_region <= 11'd1024;
            r_clr    <= '0;
            r_sib    <= 1'b0;
            r_done   <= 1'b0;
            r_free   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= i_mode;
                        r_ku    <= bit_len(32'(w_nm1));
                        r_off   <= i_block_offset;
                        r_state <= S_START;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_free  <= w_reg_size;
                        r_k     <= w_reg_log;
                        r_i     <= '0;
                        r_sib   <= 1'b0;
                        r_state <= w_empty ? S_IDLE : S_SEED;
                    end
                end
                S_SEED: r_state <= S_IDLE;
                S_START: begin
                    r_sib <= 1'b0;
                    if (!r_mode) begin
                        if (w_empty || r_ku > w_reg_log) begin
                            r_done    <= 1'b1;
                            r_status  <= 1'b1;
                            r_granted <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_k     <= r_ku;
                            r_i     <= '0;
                            r_state <= S_ARD;
                        end
                    end else if (!w_free_ok) begin
                        r_done    <= 1'b1;
                        r_status  <= 1'b1;
                        r_granted <= '0;
                        r_state   <= S_IDLE;
                    end else if (r_ku == w_reg_log) begin
                        r_k     <= '0;
                        r_i     <= IW'(w_off);
                        r_cnt   <= w_u;
                        r_state <= S_FDRD;
                    end else begin
                        r_k     <= r_ku + LVL_W'(1);
                        r_i     <= IW'(w_off >> (r_ku + LVL_W'(1)));
                        r_state <= S_FARD;
                    end
                end
                S_ARD: r_state <= S_ACHK;
                S_ACHK: begin
                    if (w_rdata) begin
                        if (r_k == r_ku) begin
                            r_done    <= 1'b1;
                            r_status  <= 1'b0;
                            r_granted <= 10'((CW'(r_i)) << r_ku);
                            r_free    <= r_free - w_u;
                            r_state   <= S_IDLE;
                        end else begin
                            r_k     <= r_k - LVL_W'(1);
                            r_i     <= r_i << 1;
                            r_sib   <= 1'b1;
                            r_state <= S_ASPW;
                        end
                    end else if (CW'(r_i) + CW'(1) == (w_reg_size >> r_k)) begin
                        if (r_k == w_reg_log) begin
                            r_done    <= 1'b1;
                            r_status  <= 1'b1;
                            r_granted <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_k     <= r_k + LVL_W'(1);
                            r_i     <= '0;
                            r_state <= S_ARD;
                        end
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_ARD;
                    end
                end
                S_ASPW: begin
                    if (r_k == r_ku) begin
                        r_sib     <= 1'b0;
                        r_done    <= 1'b1;
                        r_status  <= 1'b0;
                        r_granted <= 10'((CW'(r_i)) << r_ku);
                        r_free    <= r_free - w_u;
                        r_state   <= S_IDLE;
                    end else begin
                        r_k <= r_k - LVL_W'(1);
                        r_i <= r_i << 1;
                    end
                end
                S_FARD: r_state <= S_FACHK;
                S_FACHK: begin
                    if (w_rdata) begin
                        r_done    <= 1'b1;
                        r_status  <= 1'b1;
                        r_granted <= '0;
                        r_state   <= S_IDLE;
                    end else if (r_k == w_reg_log) begin
                        r_k     <= '0;
                        r_i     <= IW'(w_off);
                        r_cnt   <= w_u;
                        r_state <= S_FDRD;
                    end else begin
                        r_k     <= r_k + LVL_W'(1);
                        r_i     <= r_i >> 1;
                        r_state <= S_FARD;
                    end
                end
                S_FDRD: r_state <= S_FDCHK;
                S_FDCHK: begin
                    if (w_rdata) begin
                        r_done    <= 1'b1;
                        r_status  <= 1'b1;
                        r_granted <= '0;
                        r_state   <= S_IDLE;
                    end else if (r_cnt == CW'(1)) begin
                        if (r_k == r_ku) begin
                            r_i     <= IW'(w_off >> r_ku);
                            r_state <= S_MINIT;
                        end else begin
                            r_k     <= r_k + LVL_W'(1);
                            r_i     <= IW'(w_off >> (r_k + LVL_W'(1)));
                            r_cnt   <= w_u >> (r_k + LVL_W'(1));
                            r_state <= S_FDRD;
                        end
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_i     <= r_i + IW'(1);
                        r_state <= S_FDRD;
                    end
                end
                S_MINIT: begin
                    if (r_k < w_reg_log) begin
                        r_sib   <= 1'b1;
                        r_state <= S_MRD;
                    end else begin
                        r_sib   <= 1'b0;
                        r_state <= S_MSET;
                    end
                end
                S_MRD: r_state <= S_MCHK;
                S_MCHK: begin
                    if (w_rdata) begin
                        r_k <= r_k + LVL_W'(1);
                        r_i <= r_i >> 1;
                        if (r_k + LVL_W'(1) < w_reg_log) begin
                            r_state <= S_MRD;
                        end else begin
                            r_sib   <= 1'b0;
                            r_state <= S_MSET;
                        end
                    end else begin
                        r_sib   <= 1'b0;
                        r_state <= S_MSET;
                    end
                end
                S_MSET: begin
                    r_done    <= 1'b1;
                    r_status  <= 1'b0;
                    r_granted <= '0;
                    r_free    <= r_free + w_u;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_valid) begin
                r_region <= i_cfg_data;
                r_clr    <= '0;
                r_state  <= S_CLR;
            end
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_offset = r_granted;
    assign o_free_total     = r_free[10:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result word without a request in flight");

    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_granted_offset == '0))
        else $error("failed request reports an offset");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_free <= w_reg_size))
        else $error("free page total exceeds region");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_PAGES = 1024;
    localparam bit MODE_ALLOC = 1'b0;
    localparam bit MODE_FREE  = 1'b1;
    localparam bit ST_OK      = 1'b0;
    localparam bit ST_FAIL    = 1'b1;

    typedef struct packed {
        logic       status;
        logic [9:0] offset;
        logic [10:0] free_total;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [10:0] i_page_count;
    logic [9:0]  i_block_offset;
    logic        o_done;
    logic        o_status;
    logic [9:0]  o_granted_offset;
    logic [10:0] o_free_total;

    buddy_page_allocator i_dut (.*);

    // allocator model state
    bit          free_bit [0:2*TOP_PAGES-1];
    int unsigned reg_pages;
    int unsigned reg_log;
    int unsigned pages_free;

    t_grant      grant_q [$];
    int unsigned held_off [$];
    int unsigned held_sz [$];
    int          errors;
    int          idle_pct;

    function automatic int unsigned node(int unsigned k, int unsigned i);
        return (TOP_PAGES >> k) + i;
    endfunction

    function automatic void region_init(int unsigned want);
        foreach (free_bit[n]) free_bit[n] = 0;
        if (want > TOP_PAGES) want = TOP_PAGES;
        reg_pages = 0;
        reg_log = 0;
        pages_free = 0;
        if (want != 0) begin
            reg_pages = 1;
            while ((reg_pages << 1) <= want) begin
                reg_pages <<= 1;
                reg_log++;
            end
            free_bit[node(reg_log, 0)] = 1;
            pages_free = reg_pages;
        end
        held_off.delete();
        held_sz.delete();
    endfunction

    function automatic bit page_free(int unsigned p);
        for (int unsigned k = 0; k <= reg_log; k++)
            if (free_bit[node(k, p >> k)]) return 1;
        return 0;
    endfunction

    function automatic t_grant allocate_or_release(bit mode, int unsigned n, int unsigned off);
        t_grant      g;
        int unsigned u, ku, k, i;
        bit          ok;
        u = 1;
        ku = 0;
        g = '0;
        g.status = ST_FAIL;
        while (u < n) begin
            u <<= 1;
            ku++;
        end
        if (mode == MODE_ALLOC) begin
            ok = 0;
            if (reg_pages != 0 && u <= reg_pages) begin
                for (k = ku; k <= reg_log && !ok; k++) begin
                    for (i = 0; i < (reg_pages >> k); i++)
                        if (free_bit[node(k, i)]) begin
                            ok = 1;
                            break;
                        end
                    if (ok) break;
                end
            end
            if (ok) begin
                free_bit[node(k, i)] = 0;
                while (k > ku) begin
                    k--;
                    i <<= 1;
                    free_bit[node(k, i + 1)] = 1;
                end
                g.offset = 10'(i << ku);
                pages_free -= u;
                g.status = ST_OK;
                held_off.push_back(i << ku);
                held_sz.push_back(u);
            end
        end else begin
            ok = reg_pages != 0 && u <= reg_pages && (off & (u - 1)) == 0
                 && off + u <= reg_pages;
            if (ok)
                for (int unsigned p = off; p < off + u; p++)
                    if (page_free(p)) begin
                        ok = 0;
                        break;
                    end
            if (ok) begin
                k = ku;
                i = off >> ku;
                while (k < reg_log && free_bit[node(k, i ^ 1)]) begin
                    free_bit[node(k, i ^ 1)] = 0;
                    k++;
                    i >>= 1;
                end
                free_bit[node(k, i)] = 1;
                pages_free += u;
                g.status = ST_OK;
            end
        end
        g.free_total = 11'(pages_free);
        return g;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("FAIL buddy_page_allocator");
        $finish;
    end

    // result word checker
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                g = grant_q.pop_front();
                if (o_status !== g.status || o_granted_offset !== g.offset
                    || o_free_total !== g.free_total) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 g.status, g.offset, g.free_total,
                                 o_status, o_granted_offset, o_free_total);
                end
            end
        end
    end

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send(bit mode, int unsigned n, int unsigned off);
        if ($urandom_range(99) < idle_pct) idle($urandom_range(1, 6));
        start <= 1'b1;
        i_mode <= mode;
        i_page_count <= 11'(n);
        i_block_offset <= 10'(off);
        do @(posedge i_clk); while (busy);
        grant_q.push_back(allocate_or_release(mode, n, off));
    endtask

    task automatic drain();
        idle(1);
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_region(int unsigned v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 11'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        region_init(v);
    endtask

    task automatic test_directed();
        send(MODE_ALLOC, 1, 0);
        send(MODE_ALLOC, 0, 1023);
        send(MODE_ALLOC, 2047, 0);
        send(MODE_ALLOC, 1025, 0);
        send(MODE_FREE, 2, 1);
        send(MODE_FREE, 1, 2);
        send(MODE_FREE, 1, 0);
        send(MODE_FREE, 1, 0);
        send(MODE_FREE, 0, 1);
        send(MODE_ALLOC, 1024, 0);
        send(MODE_ALLOC, 1, 0);
        send(MODE_FREE, 2, 1022);
        send(MODE_FREE, 1024, 0);
        send(MODE_FREE, 2047, 0);
        write_region(0);
        send(MODE_ALLOC, 1, 0);
        send(MODE_FREE, 1, 0);
        write_region(2047);
        send(MODE_ALLOC, 512, 0);
        send(MODE_ALLOC, 1023, 0);
        write_region(1);
        send(MODE_ALLOC, 1, 0);
        send(MODE_ALLOC, 2, 0);
        send(MODE_FREE, 1, 1);
        send(MODE_FREE, 1, 0);
    endtask

    task automatic test_random(int unsigned region, int items, int pct);
        int unsigned k, j, lo;
        write_region(region);
        idle_pct = pct;
        repeat (items) begin
            k = $urandom_range(99);
            if (held_off.size() != 0 && k < 45) begin
                j = $urandom_range(held_off.size() - 1);
                lo = held_off[j];
                k = held_sz[j];
                held_off.delete(j);
                held_sz.delete(j);
                send(MODE_FREE, $urandom_range(k / 2 + 1, k), lo);
            end else if (k < 88 && reg_pages != 0) begin
                j = $urandom_range(reg_log, 0);
                if ($urandom_range(3) != 0 && j > 2) j = $urandom_range(2);
                send(MODE_ALLOC, $urandom_range((1 << j) / 2 + 1, 1 << j),
                     $urandom_range(1023));
            end else begin
                send($urandom_range(1), $urandom_range(2047), $urandom_range(1023));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        start = 1'b0;
        i_mode = 1'b0;
        i_page_count = '0;
        i_block_offset = '0;
        errors = 0;
        idle_pct = 0;
        region_init(1024);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(64, 500, 9);
        test_random(37, 450, 85);
        test_random(16, 400, 0);
        test_random(1024, 150, 9);
        test_random(200, 250, 0);
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && grant_q.size() == 0) begin
            $display("PASS buddy_page_allocator");
        end else begin
            $display("FAIL buddy_page_allocator");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/buddy_page_allocator.sv
tb/sv/tb.sv
